// ----- rtl/base64_stream_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// base64 stream decoder assertion macros
// shared property shapes for the checker, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// same-cycle implication
`define B64SD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64sd same-cycle check failed");

// next-cycle implication
`define B64SD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64sd next-cycle check failed");

`endif

// ----- rtl/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// types, codes and the symbol lookup shared by the base64 stream decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int ACC_W = 12;
    localparam int HELD_W = 4;
    localparam int CNT_W = 23;

    // sticky status codes
    typedef enum logic [1:0] {
        ERR_OK  = 2'd0,
        ERR_BAD = 2'd1,
        ERR_OVF = 2'd2
    } b64d_err_t;

    // symbol classes
    typedef enum logic [1:0] {
        SYM_DATA = 2'd0,
        SYM_PAD  = 2'd1,
        SYM_BAD  = 2'd2
    } b64d_sym_kind_t;

    typedef struct packed {
        b64d_sym_kind_t kind;
        logic [5:0]     value;
    } b64d_sym_t;

    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        logic [HELD_W-1:0] held;
        logic [CNT_W-1:0]  count;
        b64d_err_t         err;
    } b64d_state_t;

    typedef struct packed {
        logic             byte_valid;
        logic [7:0]       data_byte;
        b64d_err_t        status;
        logic [CNT_W-1:0] count;
        logic             complete;
    } b64d_result_t;

    // standard alphabet lookup
    function automatic b64d_sym_t sym_lookup(input logic [7:0] c);
        b64d_sym_t  s;
        logic [7:0] d;
        s.kind  = SYM_BAD;
        s.value = 6'd0;
        d       = 8'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            d       = c - 8'h41;
            s.kind  = SYM_DATA;
            s.value = d[5:0];
        end else if (c inside {[8'h61:8'h7A]}) begin
            d       = c - 8'h61 + 8'd26;
            s.kind  = SYM_DATA;
            s.value = d[5:0];
        end else if (c inside {[8'h30:8'h39]}) begin
            d       = c - 8'h30 + 8'd52;
            s.kind  = SYM_DATA;
            s.value = d[5:0];
        end else if (c == 8'h2B) begin
            s.kind  = SYM_DATA;
            s.value = 6'd62;
        end else if (c == 8'h2F) begin
            s.kind  = SYM_DATA;
            s.value = 6'd63;
        end else if (c == 8'h3D) begin
            s.kind  = SYM_PAD;
        end
        return s;
    endfunction

endpackage

// ----- rtl/b64d_step.sv -----
// ----------------------------------------------------------------------------
// b64d_step
// one decode step: next accumulator state and the result for one symbol
// ----------------------------------------------------------------------------
module b64d_step (
    input  b64d_pkg::b64d_state_t          state,
    input  logic                           restart,
    input  logic [7:0]                     symbol,
    input  logic [b64d_pkg::CNT_W-1:0]     cap_eff,
    output b64d_pkg::b64d_state_t          state_next,
    output b64d_pkg::b64d_result_t         result
);
    import b64d_pkg::*;

    b64d_sym_t         sym;
    logic [ACC_W-1:0]  acc_shift;
    logic [HELD_W-1:0] held_add;
    logic [HELD_W-1:0] held_sub;
    logic [ACC_W-1:0]  acc_out;
    logic              byte_due;
    logic              cap_full;

    assign sym       = sym_lookup(symbol);
    assign acc_shift = {state.acc[ACC_W-7:0], sym.value};
    assign held_add  = state.held + 4'd6;
    assign byte_due  = (held_add >= 4'd8);
    assign held_sub  = held_add - 4'd8;
    assign acc_out   = acc_shift >> held_sub;
    assign cap_full  = (state.count >= cap_eff);

    always_comb
    begin
        state_next        = state;
        result.byte_valid = 1'b0;
        result.data_byte  = 8'd0;
        if (restart)
        begin
            state_next = '{acc: '0, held: '0, count: '0, err: ERR_OK};
        end
        else if (state.err == ERR_OK)
        begin
            case (sym.kind)
                SYM_BAD:
                begin
                    state_next.err = ERR_BAD;
                end
                SYM_DATA:
                begin
                    if (!byte_due)
                    begin
                        state_next.acc  = acc_shift;
                        state_next.held = held_add;
                    end
                    else if (cap_full)
                    begin
                        state_next.err = ERR_OVF;
                    end
                    else
                    begin
                        state_next.acc    = acc_shift;
                        state_next.held   = held_sub;
                        state_next.count  = state.count + 1'b1;
                        result.byte_valid = 1'b1;
                        result.data_byte  = acc_out[7:0];
                    end
                end
                default:
                begin
                    // padding is skipped
                end
            endcase
        end
        result.status   = state_next.err;
        result.count    = state_next.count;
        result.complete = (state_next.count == cap_eff);
    end

endmodule

// ----- rtl/base64_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder
// streaming base64 text decoder with byte count, capacity check and sticky
// error status
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------------
//  input   | in_valid / in_stall        | restart, symbol
//  result  | out_valid / out_stall      | byte_valid, data_byte, status,
//          |                            | bytes_so_far, complete
//  config  | cfg_valid / cfg_ready      | capacity_bytes
//
//  one beat in and one beat out per cycle when nothing stalls
//  a beat passes through the input register, then the decode step into the result register
//  the decoder state updates as a beat leaves the input register, so the next
//  beat sees the updated state
//  out_stall holds the result register; the input register then holds and
//  in_stall rises once it is full
//  rst_n clears control state and loads capacity 1; cfg_ready is always high
//
module base64_stream_decoder #(
    parameter int MAX_BYTES = 4194304
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          restart,
    input  logic [7:0]                    symbol,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          byte_valid,
    output logic [7:0]                    data_byte,
    output logic [1:0]                    status,
    output logic [b64d_pkg::CNT_W-1:0]    bytes_so_far,
    output logic                          complete,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [b64d_pkg::CNT_W-1:0]    capacity_bytes
);
    import b64d_pkg::*;

    localparam logic [CNT_W-1:0] MaxCap = CNT_W'(MAX_BYTES);

    // capacity register
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_eff;

    // input register
    logic             in_valid_reg;
    logic             restart_reg;
    logic [7:0]       symbol_reg;

    // decoder state
    b64d_state_t      state_reg;
    b64d_state_t      state_next;

    // result register
    logic             out_valid_reg;
    b64d_result_t     result_reg;
    b64d_result_t     result_next;

    logic             out_free;
    logic             step_fire;

    assign cfg_ready = 1'b1;

    // capacity above the limit saturates, zero stays zero
    assign cap_eff = (cap_reg > MaxCap) ? MaxCap : cap_reg;

    // result register takes a new beat when empty or draining this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign step_fire = in_valid_reg && out_free;
    // input register stalls only when full and unable to move on
    assign in_stall  = in_valid_reg && !out_free;

    b64d_step u_step (
        .state      (state_reg),
        .restart    (restart_reg),
        .symbol     (symbol_reg),
        .cap_eff    (cap_eff),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= capacity_bytes;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{acc: '0, held: '0, count: '0, err: ERR_OK};
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            restart_reg <= restart;
            symbol_reg  <= symbol;
        end
        if (step_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_valid   = result_reg.byte_valid;
    assign data_byte    = result_reg.data_byte;
    assign status       = result_reg.status;
    assign bytes_so_far = result_reg.count;
    assign complete     = result_reg.complete;

endmodule

// ----- rtl/b64d_checker.sv -----
// ----------------------------------------------------------------------------
// b64d_checker
// port-level checks on the base64 stream decoder result channel
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_macros.svh"

module b64d_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        byte_valid,
    input logic [7:0]  data_byte,
    input logic [1:0]  status,
    input logic [22:0] bytes_so_far
);
    import b64d_pkg::*;

    // a held result keeps its payload
    `B64SD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data_byte) && $stable(bytes_so_far))
    // a byte only leaves while status is ok
    `B64SD_ASSERT_IMP(a_byte_ok, out_valid && byte_valid, status == ERR_OK)
    // no byte, zero data
    `B64SD_ASSERT_IMP(a_no_byte_zero, out_valid && !byte_valid, data_byte == 8'd0)
    // status never takes the unused code
    `B64SD_ASSERT_IMP(a_status_code, out_valid, status != 2'd3)

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_valid   (byte_valid),
    .data_byte    (data_byte),
    .status       (status),
    .bytes_so_far (bytes_so_far)
);
